// File: rtl/core/u8d_pkg.sv
package u8d_pkg;

    localparam logic [7:0]  ESC_BYTE    = 8'h1B;
    localparam logic [20:0] REPLACEMENT = 21'h00FFFD;

    // One queue entry: one or two results caused by a single input item.
    typedef struct packed {
        logic        two;
        logic [20:0] cp0;
        logic        esc0;
        logic [20:0] cp1;
        logic        esc1;
    } t_entry;

    typedef struct packed {
        logic empty;
        logic full;
    } t_qstat;

endpackage

// File: rtl/core/u8d_front.sv
module u8d_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_acc,
    input  logic [7:0]      i_byte,
    output u8d_pkg::t_entry o_ent,
    output logic            o_ent_vld
);
    import u8d_pkg::*;

    localparam logic [3:0] S_ACCEPT = 4'd0;
    localparam logic [3:0] S_NEED1  = 4'd1;
    localparam logic [3:0] S_NEED2  = 4'd2;
    localparam logic [3:0] S_NEED3  = 4'd3;
    localparam logic [3:0] S_E0     = 4'd4;
    localparam logic [3:0] S_ED     = 4'd5;
    localparam logic [3:0] S_F0     = 4'd6;
    localparam logic [3:0] S_F4     = 4'd7;

    localparam logic [1:0] K_PENDING = 2'd0;
    localparam logic [1:0] K_DONE    = 2'd1;
    localparam logic [1:0] K_BAD     = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  st;
        logic [20:0] pc;
    } t_lead;

    function automatic t_lead lead(input logic [7:0] b);
        t_lead l;
        l.kind = K_BAD;
        l.st   = S_ACCEPT;
        l.pc   = '0;
        if (b < 8'h80) begin
            l.kind = K_DONE;
            l.pc   = {13'd0, b};
        end else if (b < 8'hC2) begin
            l.kind = K_BAD;
        end else if (b < 8'hE0) begin
            l.kind = K_PENDING;
            l.st   = S_NEED1;
            l.pc   = {16'd0, b[4:0]};
        end else if (b < 8'hF0) begin
            l.kind = K_PENDING;
            l.st   = (b == 8'hE0) ? S_E0 : (b == 8'hED) ? S_ED : S_NEED2;
            l.pc   = {17'd0, b[3:0]};
        end else if (b < 8'hF5) begin
            l.kind = K_PENDING;
            l.st   = (b == 8'hF0) ? S_F0 : (b == 8'hF4) ? S_F4 : S_NEED3;
            l.pc   = {18'd0, b[2:0]};
        end
        return l;
    endfunction

    logic [3:0]  r_state, n_state;
    logic [20:0] r_pc, n_pc;
    logic [7:0]  lo, hi;
    logic [3:0]  nxt;
    logic        cont_legal;
    logic [20:0] cont_pc;
    t_lead       ld;

    assign ld      = lead(i_byte);
    assign cont_pc = {r_pc[14:0], i_byte[5:0]};

    always_comb begin
        lo         = 8'h80;
        hi         = 8'hBF;
        nxt        = S_ACCEPT;
        cont_legal = 1'b1;
        unique case (r_state)
            S_NEED1: nxt = S_ACCEPT;
            S_NEED2: nxt = S_NEED1;
            S_NEED3: nxt = S_NEED2;
            S_E0: begin lo = 8'hA0; nxt = S_NEED1; end
            S_ED: begin hi = 8'h9F; nxt = S_NEED1; end
            S_F0: begin lo = 8'h90; nxt = S_NEED2; end
            S_F4: begin hi = 8'h8F; nxt = S_NEED2; end
            default: cont_legal = 1'b0;
        endcase
    end

    always_comb begin
        n_state   = S_ACCEPT;
        n_pc      = '0;
        o_ent_vld = 1'b0;
        o_ent     = '{two: 1'b0, cp0: REPLACEMENT, esc0: 1'b0, cp1: '0, esc1: 1'b1};
        if (i_byte == ESC_BYTE) begin
            o_ent_vld = 1'b1;
            if (r_state != S_ACCEPT) begin
                o_ent.two = 1'b1;
            end else begin
                o_ent.cp0  = '0;
                o_ent.esc0 = 1'b1;
            end
        end else if (r_state == S_ACCEPT) begin
            unique case (ld.kind)
                K_DONE: begin
                    o_ent_vld = 1'b1;
                    o_ent.cp0 = ld.pc;
                end
                K_PENDING: begin
                    n_state = ld.st;
                    n_pc    = ld.pc;
                end
                default: o_ent_vld = 1'b1;
            endcase
        end else if (cont_legal && i_byte >= lo && i_byte <= hi) begin
            if (nxt == S_ACCEPT) begin
                o_ent_vld = 1'b1;
                o_ent.cp0 = cont_pc;
            end else begin
                n_state = nxt;
                n_pc    = cont_pc;
            end
        end else begin
            // broken sequence: replacement, then decode the byte afresh
            o_ent_vld = 1'b1;
            unique case (ld.kind)
                K_DONE: begin
                    o_ent.two  = 1'b1;
                    o_ent.cp1  = ld.pc;
                    o_ent.esc1 = 1'b0;
                end
                K_PENDING: begin
                    n_state = ld.st;
                    n_pc    = ld.pc;
                end
                default: begin
                    o_ent.two  = 1'b1;
                    o_ent.cp1  = REPLACEMENT;
                    o_ent.esc1 = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_ACCEPT;
            r_pc    <= '0;
        end else if (i_acc) begin
            r_state <= n_state;
            r_pc    <= n_pc;
        end
    end

endmodule

// File: rtl/core/u8d_queue.sv
module u8d_queue #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr,
    input  u8d_pkg::t_entry i_ent,
    input  logic            i_rd,
    output u8d_pkg::t_entry o_ent,
    output u8d_pkg::t_qstat o_stat
);
    import u8d_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_entry        r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;
    logic          wr_en, rd_en;

    assign o_stat.empty = (r_cnt == '0);
    assign o_stat.full  = (r_cnt == CW'(DEPTH));
    assign wr_en        = i_wr && !o_stat.full;
    assign rd_en        = i_rd && !o_stat.empty;
    assign o_ent        = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wp] <= i_ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (rd_en) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// File: rtl/core/u8d_back.sv
module u8d_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  u8d_pkg::t_entry i_ent,
    input  logic            i_empty,
    input  logic            i_pop,
    output logic            o_deq,
    output logic [20:0]     o_code_point,
    output logic            o_escape_seen,
    output logic            o_last
);
    import u8d_pkg::*;

    logic r_sub;
    logic take;

    assign take          = i_pop && !i_empty;
    assign o_last        = r_sub || !i_ent.two;
    assign o_code_point  = r_sub ? i_ent.cp1 : i_ent.cp0;
    assign o_escape_seen = r_sub ? i_ent.esc1 : i_ent.esc0;
    assign o_deq         = take && o_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub <= 1'b0;
        end else if (take) begin
            r_sub <= !o_last;
        end
    end

endmodule

// File: rtl/core/utf8_decode_until_escape_top.sv
// channel   direction  handshake          payload
// input     in         push / full        i_in_byte[7:0]
// result    out        empty / pop        o_code_point[20:0], o_escape_seen, o_last
//
// One byte is accepted per cycle while full is low; the front stage decodes
// each byte combinationally against its registered decoder state.
// Each byte queues at most one entry of one or two results; a byte that leaves
// a sequence pending queues nothing unless it broke one before. The back stage
// drains one result per cycle when popped and not empty; a pair takes two pops.
// full rises only when the entry queue (QDEPTH entries) fills.
// Synchronous reset clears the decoder state and empties the queue.
module utf8_decode_until_escape_top #(
    parameter int QDEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_in_byte,
    output logic        empty,
    input  logic        pop,
    output logic [20:0] o_code_point,
    output logic        o_escape_seen,
    output logic        o_last
);
    import u8d_pkg::*;

    t_entry f_ent, q_ent;
    t_qstat q_stat;
    logic   f_vld, acc, deq;

    assign acc   = push && !q_stat.full;
    assign full  = q_stat.full;
    assign empty = q_stat.empty;

    u8d_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_acc     (acc),
        .i_byte    (i_in_byte),
        .o_ent     (f_ent),
        .o_ent_vld (f_vld)
    );

    u8d_queue #(.DEPTH(QDEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (acc && f_vld),
        .i_ent   (f_ent),
        .i_rd    (deq),
        .o_ent   (q_ent),
        .o_stat  (q_stat)
    );

    u8d_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ent         (q_ent),
        .i_empty       (q_stat.empty),
        .i_pop         (pop),
        .o_deq         (deq),
        .o_code_point  (o_code_point),
        .o_escape_seen (o_escape_seen),
        .o_last        (o_last)
    );

endmodule

// File: rtl/core/u8d_checker.sv
module u8d_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic [20:0] o_code_point,
    input logic        o_escape_seen,
    input logic        o_last
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("queue not empty after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> !empty && $stable(o_code_point) && $stable(o_escape_seen)
            && $stable(o_last))
        else $error("waiting result changed");

    a_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop && !o_last) |=> !empty)
        else $error("second result of an item missing");

    a_escape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_escape_seen) |-> (o_code_point == 21'd0) && o_last)
        else $error("escape marker malformed");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_code_point <= 21'h10FFFF))
        else $error("code point out of range");

endmodule

bind utf8_decode_until_escape_top u8d_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .full          (full),
    .empty         (empty),
    .pop           (pop),
    .o_code_point  (o_code_point),
    .o_escape_seen (o_escape_seen),
    .o_last        (o_last)
);

// File: test/tb_utf8_decode_until_escape_top.sv
`timescale 1ns / 1ps

module tb_utf8_decode_until_escape_top;
    import u8d_pkg::*;

    localparam int RAND_ITEMS = 950;
    localparam int IDLE_LIMIT = 1000;
    localparam int TAIL_CYCLES = 20;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CONT1 = 4'd1;
    localparam logic [3:0] S_CONT2 = 4'd2;
    localparam logic [3:0] S_CONT3 = 4'd3;
    localparam logic [3:0] S_E0    = 4'd4;
    localparam logic [3:0] S_ED    = 4'd5;
    localparam logic [3:0] S_F0    = 4'd6;
    localparam logic [3:0] S_F4    = 4'd7;

    localparam int RX_FREE  = 0;
    localparam int RX_LIGHT = 1;
    localparam int RX_HEAVY = 2;
    localparam int RX_HALF  = 3;

    typedef enum logic [1:0] {FEED_MORE, FEED_DONE, FEED_BAD} t_feed;

    typedef struct packed {
        logic [20:0] cp;
        logic        esc;
        logic        last;
    } t_cp_res;

    typedef struct {
        logic [7:0]  b;
        bit          typed;
        int          n;
        logic [20:0] cp0;
        bit          esc0;
        logic [20:0] cp1;
        bit          esc1;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  i_in_byte = 8'h00;
    logic        empty;
    logic        pop = 1'b0;
    logic [20:0] o_code_point;
    logic        o_escape_seen;
    logic        o_last;

    utf8_decode_until_escape_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_in_byte     (i_in_byte),
        .empty         (empty),
        .pop           (pop),
        .o_code_point  (o_code_point),
        .o_escape_seen (o_escape_seen),
        .o_last        (o_last)
    );

    always #1 i_clk = ~i_clk;

    // typed rows: n results, last set on the final one
    t_stim_row dir_tab [25] = '{
        '{8'h00,    1'b1, 1, 21'h000000,  1'b0, 21'h0, 1'b0},
        '{8'h7F,    1'b1, 1, 21'h00007F,  1'b0, 21'h0, 1'b0},
        '{ESC_BYTE, 1'b1, 1, 21'h000000,  1'b1, 21'h0, 1'b0},
        '{8'h80,    1'b1, 1, REPLACEMENT, 1'b0, 21'h0, 1'b0},
        '{8'hFF,    1'b1, 1, REPLACEMENT, 1'b0, 21'h0, 1'b0},
        '{8'hC2,    1'b1, 0, 21'h0,       1'b0, 21'h0, 1'b0},
        '{ESC_BYTE, 1'b1, 2, REPLACEMENT, 1'b0, 21'h0, 1'b1},
        '{8'hC2,    1'b0, 0, 21'h0,       1'b0, 21'h0, 1'b0},
        '{8'hC2,    1'b0, 0, 21'h0,       1'b0, 21'h0, 1'b0},
        '{8'h41,    1'b0, 0, 21'h0,       1'b0, 21'h0, 1'b0},
        '{8'hE0,    1'b0, 0, 21'h0,       1'b0, 21'h0, 1'b0},
        '{8'h80,    1'b1, 2, REPLACEMENT, 1'b0, REPLACEMENT, 1'b0},
        '{8'hED,    1'b0, 0, 21'h0,       1'b0, 21'h0, 1'b0},
        '{8'hA0,    1'b0, 0, 21'h0,       1'b0, 21'h0, 1'b0},
        '{8'hF4,    1'b0, 0, 21'h0,       1'b0, 21'h0, 1'b0},
        '{8'h8F,    1'b0, 0, 21'h0,       1'b0, 21'h0, 1'b0},
        '{8'hBF,    1'b0, 0, 21'h0,       1'b0, 21'h0, 1'b0},
        '{8'hBF,    1'b1, 1, 21'h10FFFF,  1'b0, 21'h0, 1'b0},
        '{8'hF0,    1'b0, 0, 21'h0,       1'b0, 21'h0, 1'b0},
        '{8'h90,    1'b0, 0, 21'h0,       1'b0, 21'h0, 1'b0},
        '{8'h80,    1'b0, 0, 21'h0,       1'b0, 21'h0, 1'b0},
        '{8'h80,    1'b0, 0, 21'h0,       1'b0, 21'h0, 1'b0},
        '{8'hEF,    1'b0, 0, 21'h0,       1'b0, 21'h0, 1'b0},
        '{8'hBF,    1'b0, 0, 21'h0,       1'b0, 21'h0, 1'b0},
        '{8'hBF,    1'b0, 0, 21'h0,       1'b0, 21'h0, 1'b0}
    };

    logic [3:0]  dec_state = S_IDLE;
    logic [20:0] dec_acc = '0;
    t_cp_res     fresh_q [$];
    t_cp_res     cp_exp_q [$];
    t_cp_res     want;
    t_stim_row   cur_row;
    logic [7:0]  seq_q [$];
    int          errors = 0;
    int          idle_cycles = 0;
    int          burst_left = 0;
    int          stall_mode = RX_FREE;
    int          stall_left = 0;

    function automatic t_feed dec_lead(input logic [7:0] b);
        if (b < 8'h80) begin
            dec_acc = {13'd0, b};
            dec_state = S_IDLE;
            return FEED_DONE;
        end
        if (b < 8'hC2) return FEED_BAD;
        if (b < 8'hE0) begin
            dec_acc = {16'd0, b[4:0]};
            dec_state = S_CONT1;
            return FEED_MORE;
        end
        if (b < 8'hF0) begin
            dec_acc = {17'd0, b[3:0]};
            dec_state = (b == 8'hE0) ? S_E0 : (b == 8'hED) ? S_ED : S_CONT2;
            return FEED_MORE;
        end
        if (b < 8'hF5) begin
            dec_acc = {18'd0, b[2:0]};
            dec_state = (b == 8'hF0) ? S_F0 : (b == 8'hF4) ? S_F4 : S_CONT3;
            return FEED_MORE;
        end
        return FEED_BAD;
    endfunction

    function automatic t_feed dec_feed(input logic [7:0] b);
        logic [7:0] lo;
        logic [7:0] hi;
        logic [3:0] nxt;
        lo = 8'h80;
        hi = 8'hBF;
        if (dec_state == S_IDLE) return dec_lead(b);
        case (dec_state)
            S_CONT1: nxt = S_IDLE;
            S_CONT2: nxt = S_CONT1;
            S_CONT3: nxt = S_CONT2;
            S_E0: begin
                lo = 8'hA0;
                nxt = S_CONT1;
            end
            S_ED: begin
                hi = 8'h9F;
                nxt = S_CONT1;
            end
            S_F0: begin
                lo = 8'h90;
                nxt = S_CONT2;
            end
            S_F4: begin
                hi = 8'h8F;
                nxt = S_CONT2;
            end
            default: return FEED_BAD;
        endcase
        if (b < lo || b > hi) return FEED_BAD;
        dec_acc = {dec_acc[14:0], b[5:0]};
        dec_state = nxt;
        return (nxt == S_IDLE) ? FEED_DONE : FEED_MORE;
    endfunction

    // fills fresh_q with the results one byte causes
    function automatic void decode_byte(input logic [7:0] b);
        bit    was_pending;
        t_feed r;
        fresh_q.delete();
        if (b == ESC_BYTE) begin
            if (dec_state != S_IDLE) fresh_q.push_back('{REPLACEMENT, 1'b0, 1'b0});
            fresh_q.push_back('{21'd0, 1'b1, 1'b0});
            dec_state = S_IDLE;
            dec_acc = '0;
        end else begin
            was_pending = (dec_state != S_IDLE);
            r = dec_feed(b);
            if (r == FEED_DONE) begin
                fresh_q.push_back('{dec_acc, 1'b0, 1'b0});
            end else if (r == FEED_BAD) begin
                dec_state = S_IDLE;
                dec_acc = '0;
                fresh_q.push_back('{REPLACEMENT, 1'b0, 1'b0});
                if (was_pending) begin
                    r = dec_feed(b);
                    if (r == FEED_DONE) begin
                        fresh_q.push_back('{dec_acc, 1'b0, 1'b0});
                    end else if (r == FEED_BAD) begin
                        dec_state = S_IDLE;
                        dec_acc = '0;
                        fresh_q.push_back('{REPLACEMENT, 1'b0, 1'b0});
                    end
                end
            end
        end
        if (fresh_q.size() > 0) fresh_q[fresh_q.size() - 1].last = 1'b1;
    endfunction

    // mostly well-formed sequences; some truncated, corrupted, or plain noise
    function automatic void build_seq();
        int         kind;
        int         cut;
        logic [7:0] lead;
        seq_q.delete();
        kind = $urandom_range(0, 99);
        if (kind < 25) begin
            seq_q.push_back(8'($urandom_range(0, 127)));
        end else if (kind < 40) begin
            seq_q.push_back(8'($urandom_range(8'hC2, 8'hDF)));
            seq_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
        end else if (kind < 60) begin
            lead = 8'($urandom_range(8'hE0, 8'hEF));
            seq_q.push_back(lead);
            if (lead == 8'hE0) seq_q.push_back(8'($urandom_range(8'hA0, 8'hBF)));
            else if (lead == 8'hED) seq_q.push_back(8'($urandom_range(8'h80, 8'h9F)));
            else seq_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
            seq_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
        end else if (kind < 75) begin
            lead = 8'($urandom_range(8'hF0, 8'hF4));
            seq_q.push_back(lead);
            if (lead == 8'hF0) seq_q.push_back(8'($urandom_range(8'h90, 8'hBF)));
            else if (lead == 8'hF4) seq_q.push_back(8'($urandom_range(8'h80, 8'h8F)));
            else seq_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
            seq_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
            seq_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
        end else if (kind < 83) begin
            seq_q.push_back(ESC_BYTE);
        end else begin
            repeat ($urandom_range(1, 3)) seq_q.push_back(8'($urandom_range(0, 255)));
        end
        if (seq_q.size() > 1 && $urandom_range(0, 9) == 0) begin
            cut = $urandom_range(1, seq_q.size() - 1);
            seq_q[cut] = 8'($urandom_range(0, 255));
        end
        if (seq_q.size() > 1 && $urandom_range(0, 7) == 0) begin
            cut = $urandom_range(0, seq_q.size() - 2);
            seq_q = seq_q[0:cut];
            if ($urandom_range(0, 2) == 0) seq_q.push_back(ESC_BYTE);
            else seq_q.push_back(8'($urandom_range(0, 255)));
        end
    endfunction

    task automatic send_item(input t_stim_row row);
        @(negedge i_clk);
        cur_row = row;
        push <= 1'b1;
        i_in_byte <= row.b;
        do @(posedge i_clk); while (full);
    endtask

    task automatic pace();
        int gap;
        burst_left = burst_left - 1;
        if (burst_left <= 0) begin
            gap = $urandom_range(1, 12);
            @(negedge i_clk);
            push <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
            burst_left = $urandom_range(1, 48);
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        push <= 1'b0;
        while (cp_exp_q.size() != 0) @(posedge i_clk);
    endtask

    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(RX_FREE, RX_HALF);
            stall_left = $urandom_range(16, 128);
        end else begin
            stall_left = stall_left - 1;
        end
        case (stall_mode)
            RX_FREE:  pop <= 1'b1;
            RX_LIGHT: pop <= ($urandom_range(0, 3) != 0);
            RX_HEAVY: pop <= ($urandom_range(0, 3) == 0);
            default:  pop <= 1'($urandom_range(0, 1));
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (pop && !empty) begin
                if (cp_exp_q.size() == 0) begin
                    errors++;
                    $error("unexpected result: code_point=%h escape_seen=%b last=%b",
                           o_code_point, o_escape_seen, o_last);
                end else begin
                    want = cp_exp_q.pop_front();
                    if (o_code_point !== want.cp) begin
                        errors++;
                        $error("code_point: expected %h, got %h", want.cp, o_code_point);
                    end
                    if (o_escape_seen !== want.esc) begin
                        errors++;
                        $error("escape_seen: expected %b, got %b", want.esc, o_escape_seen);
                    end
                    if (o_last !== want.last) begin
                        errors++;
                        $error("last: expected %b, got %b", want.last, o_last);
                    end
                end
            end
            if (push && !full) begin
                decode_byte(i_in_byte);
                if (cur_row.typed) begin
                    for (int k = 0; k < cur_row.n; k++) begin
                        cp_exp_q.push_back('{(k == 0) ? cur_row.cp0 : cur_row.cp1,
                                             (k == 0) ? cur_row.esc0 : cur_row.esc1,
                                             k == cur_row.n - 1});
                    end
                end else begin
                    foreach (fresh_q[k]) cp_exp_q.push_back(fresh_q[k]);
                end
            end
            if ((pop && !empty) || (push && !full)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin
        int        sent;
        bit        drained;
        t_stim_row rr;
        sent = 0;
        drained = 1'b0;
        rr = '{default: '0};
        burst_left = $urandom_range(1, 48);
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[i]) begin
            send_item(dir_tab[i]);
            pace();
        end
        drain();

        while (sent < RAND_ITEMS) begin
            build_seq();
            foreach (seq_q[j]) begin
                rr.b = seq_q[j];
                send_item(rr);
                sent++;
                pace();
            end
            if (!drained && sent >= RAND_ITEMS / 2) begin
                drain();
                drained = 1'b1;
            end
        end
        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (errors == 0 && cp_exp_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
